/* sv/battery_level_monitor_core_defines.svh */
// Assertion macros for the battery level monitor core.
`ifndef BATTERY_LEVEL_MONITOR_CORE_DEFINES_SVH
`define BATTERY_LEVEL_MONITOR_CORE_DEFINES_SVH

`ifndef SYNTH
// Check that cons holds in the same cycle whenever ante holds.
`define BLM_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("battery level monitor check failed");
// Check that cond holds on every clock edge out of reset.
`define BLM_ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) 1'b1 |-> (cond)) \
        else $error("battery level monitor invariant failed");
`else
`define BLM_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define BLM_ASSERT_ALWAYS(label, clk, rst_n, cond)
`endif

`endif

/* sv/blm_pkg.sv */
// Shared types and constants for the battery level monitor core.
package blm_pkg;

    // Default ADC sample width and fixed field widths
    localparam int SAMPLE_BITS_DEFAULT = 12;
    localparam int FIELD_BITS          = 12;
    localparam int COUNT_BITS          = 16;
    localparam int TAKEN_BITS          = 4;

    // Trimmed mean grouping
    localparam int GROUP_SIZE = 10;
    localparam int AVG_SHIFT  = 3;

    // Hysteresis counter ceiling
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = 16'hFFFF;

    // Register reset values
    localparam logic [FIELD_BITS-1:0] LOW_THRESHOLD_RESET     = 12'd1427;
    localparam logic [FIELD_BITS-1:0] RECOVER_THRESHOLD_RESET = 12'd1673;
    localparam logic [COUNT_BITS-1:0] COUNT_LIMIT_RESET       = 16'd60000;

    // Configuration register indexes
    localparam int CFG_INDEX_BITS = 2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_LOW_THRESHOLD     = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_RECOVER_THRESHOLD = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_COUNT_LIMIT       = 2'd2;

    // Input word: one pass
    typedef struct packed {
        logic [FIELD_BITS-1:0] sample;
        logic                  tick;
        logic                  lamp_on;
        logic                  user_ack;
    } in_word_t;

    // Result word: one per pass
    typedef struct packed {
        logic [FIELD_BITS-1:0] average;
        logic                  average_ready;
        logic                  low_alarm;
        logic                  blink_request;
        logic                  alarm_entered;
        logic                  alarm_cleared;
        logic [COUNT_BITS-1:0] hysteresis_count;
    } out_word_t;

endpackage

/* sv/battery_level_monitor_core.sv */
// Battery level monitor: trimmed mean filter and low battery alarm.
// The result word is registered and becomes valid in the cycle after its input word is accepted.
// Throughput: one word per cycle while out_ready takes results; the state update (sum, trim, threshold
// compare, hysteresis counter step) completes in a single pass.
// Reset: async active low; thresholds and limit return to defaults, filter
// group, counter, alarm, blink and pending tick clear; no result is held.
`include "battery_level_monitor_core_defines.svh"

module battery_level_monitor_core
    import blm_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  in_word_t                  in_data,
    output logic                      out_valid,
    input  logic                      out_ready,
    output out_word_t                 out_data,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [COUNT_BITS-1:0]     cfg_data
);

    localparam int SUM_BITS = SAMPLE_BITS + 4;
    localparam int CMP_BITS = (SAMPLE_BITS > FIELD_BITS) ? SAMPLE_BITS : FIELD_BITS;
    localparam logic [SAMPLE_BITS-1:0] SAMPLE_ONES = {SAMPLE_BITS{1'b1}};

    // Configuration registers
    logic [FIELD_BITS-1:0] low_thr_reg;
    logic [FIELD_BITS-1:0] rec_thr_reg;
    logic [COUNT_BITS-1:0] limit_reg;

    // Filter and alarm state
    logic [SUM_BITS-1:0]    sum_reg, sum_next;
    logic [SAMPLE_BITS-1:0] largest_reg, largest_next;
    logic [SAMPLE_BITS-1:0] smallest_reg, smallest_next;
    logic [TAKEN_BITS-1:0]  taken_reg, taken_next;
    logic [SAMPLE_BITS-1:0] level_reg, level_next;
    logic [COUNT_BITS-1:0]  count_reg, count_next;
    logic                   alarm_reg, alarm_next;
    logic                   blink_reg, blink_next;
    logic                   pend_reg, pend_next;

    // Result register
    logic      out_valid_reg;
    out_word_t out_data_reg, out_data_next;

    // Pass datapath
    logic                   accept;
    logic [SAMPLE_BITS-1:0] samp;
    logic [SUM_BITS-1:0]    sum_add;
    logic [SUM_BITS-1:0]    trimmed;
    logic [SAMPLE_BITS-1:0] big_new, small_new;
    logic [TAKEN_BITS-1:0]  taken_inc;
    logic                   group_done;
    logic                   pend;
    logic                   level_below, level_above;
    logic [COUNT_BITS-1:0]  count_up, count_dn, count_step;
    logic                   entered, cleared;

    assign accept    = in_valid && in_ready;
    assign in_ready  = !out_valid_reg || out_ready;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Filter: accumulate, track extremes, trim at group end
    assign samp       = SAMPLE_BITS'(in_data.sample);
    assign sum_add    = sum_reg + SUM_BITS'(samp);
    assign big_new    = (samp > largest_reg) ? samp : largest_reg;
    assign small_new  = (samp < smallest_reg) ? samp : smallest_reg;
    assign taken_inc  = taken_reg + TAKEN_BITS'(1);
    assign group_done = taken_inc >= TAKEN_BITS'(GROUP_SIZE);
    assign trimmed    = sum_add - SUM_BITS'(big_new) - SUM_BITS'(small_new);
    assign level_next = group_done ? SAMPLE_BITS'(trimmed >> AVG_SHIFT) : level_reg;

    always_comb
    begin
        if (group_done)
        begin
            sum_next      = '0;
            largest_next  = '0;
            smallest_next = SAMPLE_ONES;
            taken_next    = '0;
        end
        else
        begin
            sum_next      = sum_add;
            largest_next  = big_new;
            smallest_next = small_new;
            taken_next    = taken_inc;
        end
    end

    // Hysteresis counter candidates
    assign pend        = pend_reg || in_data.tick;
    assign level_below = CMP_BITS'(level_next) < CMP_BITS'(low_thr_reg);
    assign level_above = CMP_BITS'(level_next) > CMP_BITS'(rec_thr_reg);
    assign count_up    = (pend && count_reg != COUNT_MAX) ? count_reg + COUNT_BITS'(1)
                                                          : count_reg;
    assign count_dn    = (count_reg != '0) ? count_reg - COUNT_BITS'(1) : count_reg;

    // Alarm decision
    always_comb
    begin
        count_step = count_reg;
        count_next = count_reg;
        pend_next  = pend;
        alarm_next = alarm_reg;
        blink_next = blink_reg && !in_data.user_ack;
        entered    = 1'b0;
        cleared    = 1'b0;
        if (!alarm_reg)
        begin
            if (in_data.lamp_on)
            begin
                if (level_below)
                begin
                    count_step = count_up;
                    pend_next  = 1'b0;
                end
                else
                begin
                    count_step = count_dn;
                end
                if (count_step > limit_reg)
                begin
                    count_next = '0;
                    alarm_next = 1'b1;
                    blink_next = 1'b1;
                    entered    = 1'b1;
                end
                else
                begin
                    count_next = count_step;
                end
            end
            else
            begin
                count_next = '0;
            end
        end
        else
        begin
            if (level_above)
            begin
                count_step = count_up;
                pend_next  = 1'b0;
                if (count_step > limit_reg)
                begin
                    count_next = '0;
                    alarm_next = 1'b0;
                    blink_next = 1'b0;
                    cleared    = 1'b1;
                end
                else
                begin
                    count_next = count_step;
                end
            end
            else
            begin
                count_next = count_dn;
            end
        end
    end

    // Assemble the result word
    always_comb
    begin
        out_data_next.average          = FIELD_BITS'(level_next);
        out_data_next.average_ready    = group_done;
        out_data_next.low_alarm        = alarm_next;
        out_data_next.blink_request    = blink_next;
        out_data_next.alarm_entered    = entered;
        out_data_next.alarm_cleared    = cleared;
        out_data_next.hysteresis_count = count_next;
    end

    // Hold configuration and state; advance state on each accepted word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_thr_reg   <= LOW_THRESHOLD_RESET;
            rec_thr_reg   <= RECOVER_THRESHOLD_RESET;
            limit_reg     <= COUNT_LIMIT_RESET;
            sum_reg       <= '0;
            largest_reg   <= '0;
            smallest_reg  <= SAMPLE_ONES;
            taken_reg     <= '0;
            level_reg     <= '0;
            count_reg     <= '0;
            alarm_reg     <= 1'b0;
            blink_reg     <= 1'b0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_LOW_THRESHOLD:     low_thr_reg <= FIELD_BITS'(cfg_data);
                    CFG_RECOVER_THRESHOLD: rec_thr_reg <= FIELD_BITS'(cfg_data);
                    CFG_COUNT_LIMIT:       limit_reg   <= cfg_data;
                    default:               ;
                endcase
            end
            if (accept)
            begin
                sum_reg      <= sum_next;
                largest_reg  <= largest_next;
                smallest_reg <= smallest_next;
                taken_reg    <= taken_next;
                level_reg    <= level_next;
                count_reg    <= count_next;
                alarm_reg    <= alarm_next;
                blink_reg    <= blink_next;
                pend_reg     <= pend_next;
            end
            if (accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Capture the result word
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            out_data_reg <= out_data_next;
        end
    end

    // Checks
    `BLM_ASSERT_ALWAYS(a_group_bound, clk, rst_n, taken_reg < TAKEN_BITS'(GROUP_SIZE))
    `BLM_ASSERT_ALWAYS(a_blink_needs_alarm, clk, rst_n, !blink_reg || alarm_reg)
    `BLM_ASSERT_IMPLIES(a_pulse_excl, clk, rst_n, out_valid_reg, !(out_data_reg.alarm_entered && out_data_reg.alarm_cleared))
    `BLM_ASSERT_IMPLIES(a_entered_state, clk, rst_n, out_valid_reg && out_data_reg.alarm_entered, out_data_reg.low_alarm && out_data_reg.blink_request && out_data_reg.hysteresis_count == '0)
    `BLM_ASSERT_IMPLIES(a_cleared_state, clk, rst_n, out_valid_reg && out_data_reg.alarm_cleared, !out_data_reg.low_alarm && !out_data_reg.blink_request)

endmodule

/* test/tb.sv */
// Self-checking testbench for the battery level monitor core.
`timescale 1ns / 1ps

module tb;
    import blm_pkg::*;

    // Register index that maps to no register
    localparam logic [CFG_INDEX_BITS-1:0] CFG_UNMAPPED = 2'd3;
    localparam int HOLD_CYCLES  = 300;
    localparam int SAT_PASSES   = 40;
    localparam int PHASE_PASSES = 70;
    localparam logic [FIELD_BITS-1:0] SAMPLE_TOP = '1;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                      in_valid = 1'b0;
    logic                      in_ready;
    in_word_t                  in_data = '0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    out_word_t                 out_data;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [COUNT_BITS-1:0]     cfg_data = '0;

    // Pacing controls for sender and receiver, and the mismatch count
    logic pace_free = 1'b0;
    logic hold_request = 1'b0;
    int   burst_left = 0;
    int   mismatches = 0;

    // Predicted results in order of acceptance
    out_word_t expected_results [$];

    // Monitor state as predicted
    logic [COUNT_BITS-1:0] grp_sum;
    logic [FIELD_BITS-1:0] grp_max;
    logic [FIELD_BITS-1:0] grp_min;
    logic [TAKEN_BITS-1:0] grp_count;
    logic [FIELD_BITS-1:0] level;
    logic [COUNT_BITS-1:0] hyst;
    logic                  alarm_on;
    logic                  blink_on;
    logic                  tick_held;
    logic [FIELD_BITS-1:0] thr_low;
    logic [FIELD_BITS-1:0] thr_recover;
    logic [COUNT_BITS-1:0] hyst_limit;

    battery_level_monitor_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    // Start a new group of ten samples
    task automatic clear_group();
        grp_sum   = '0;
        grp_max   = '0;
        grp_min   = SAMPLE_TOP;
        grp_count = '0;
    endtask

    // Step the counter up only when a tick is waiting, and use the tick
    task automatic consume_tick();
        if (tick_held)
        begin
            if (hyst != COUNT_MAX)
                hyst = hyst + 1'b1;
            tick_held = 1'b0;
        end
    endtask

    // Step the counter down, holding at zero
    task automatic decay_count();
        if (hyst != '0)
            hyst = hyst - 1'b1;
    endtask

    // Advance the predicted monitor by one pass and build its result word
    task automatic predict_pass(input in_word_t w, output out_word_t r);
        logic [COUNT_BITS-1:0] trimmed;
        r = '0;
        if (w.tick)
            tick_held = 1'b1;
        if (w.user_ack)
            blink_on = 1'b0;

        // accumulate, drop the extremes at the tenth sample
        grp_sum = grp_sum + COUNT_BITS'(w.sample);
        if (w.sample > grp_max)
            grp_max = w.sample;
        if (w.sample < grp_min)
            grp_min = w.sample;
        grp_count = grp_count + 1'b1;
        if (grp_count >= GROUP_SIZE)
        begin
            trimmed = grp_sum - COUNT_BITS'(grp_max) - COUNT_BITS'(grp_min);
            level = FIELD_BITS'(trimmed >> AVG_SHIFT);
            r.average_ready = 1'b1;
            clear_group();
        end

        // hysteresis toward alarm or toward recovery
        if (!alarm_on)
        begin
            if (w.lamp_on)
            begin
                if (level < thr_low)
                    consume_tick();
                else
                    decay_count();
                if (hyst > hyst_limit)
                begin
                    hyst = '0;
                    alarm_on = 1'b1;
                    blink_on = 1'b1;
                    r.alarm_entered = 1'b1;
                end
            end
            else
                hyst = '0;
        end
        else if (level > thr_recover)
        begin
            consume_tick();
            if (hyst > hyst_limit)
            begin
                alarm_on = 1'b0;
                blink_on = 1'b0;
                hyst = '0;
                r.alarm_cleared = 1'b1;
            end
        end
        else
            decay_count();

        r.average          = level;
        r.low_alarm        = alarm_on;
        r.blink_request    = blink_on;
        r.hysteresis_count = hyst;
    endtask

    function automatic in_word_t pass_word(logic [FIELD_BITS-1:0] s, logic t, logic l,
                                           logic a);
        in_word_t w;
        w.sample   = s;
        w.tick     = t;
        w.lamp_on  = l;
        w.user_ack = a;
        return w;
    endfunction

    // Offer one word, wait for it to be taken, then maybe pause between bursts
    task automatic send_word(in_word_t w);
        out_word_t r;
        in_valid <= 1'b1;
        in_data  <= w;
        do @(posedge clk); while (!in_ready);
        predict_pass(w, r);
        expected_results.push_back(r);
        if (!pace_free)
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(40, 1);
                in_valid <= 1'b0;
                repeat ($urandom_range(6, 1)) @(posedge clk);
            end
            else
                burst_left--;
        end
    endtask

    // Drop valid and let every outstanding result come back
    task automatic drain_results();
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    // Write one register while the block is idle
    task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [COUNT_BITS-1:0] value);
        drain_results();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_LOW_THRESHOLD:     thr_low = value[FIELD_BITS-1:0];
            CFG_RECOVER_THRESHOLD: thr_recover = value[FIELD_BITS-1:0];
            CFG_COUNT_LIMIT:       hyst_limit = value;
            default: ;
        endcase
    endtask

    task automatic check_field(string fname, int unsigned want, int unsigned got);
        if (want != got)
        begin
            mismatches++;
            if (mismatches <= 40)
                $display("%0t: %s expected %0d, got %0d", $time, fname, want, got);
        end
    endtask

    // One group with all-ones, all-zeros and alternating bit patterns
    task automatic test_group_extremes();
        logic [FIELD_BITS-1:0] pattern [10] = '{12'hFFF, 12'h000, 12'hAAA, 12'h555,
                                                12'h800, 12'h7FF, 12'h001, 12'hFFE,
                                                12'h0F0, 12'hF0F};
        int i;
        for (i = 0; i < 10; i++)
            send_word(pass_word(pattern[i], 1'(i % 2), i != 4, i == 6));
    endtask

    // Limit of one: enter the alarm, ignore the lamp in alarm, recover
    task automatic test_alarm_cycle();
        int i;
        write_reg(CFG_LOW_THRESHOLD, 16'h0FFF);
        write_reg(CFG_RECOVER_THRESHOLD, 16'h0000);
        write_reg(CFG_COUNT_LIMIT, 16'd1);
        for (i = 0; i < 14; i++)
            send_word(pass_word(FIELD_BITS'(200 + 37 * i), (i % 4) != 3, (i % 5) != 2, i == 9));
    endtask

    // Unmapped index, lowest low threshold, oversized recover value, largest legal limit
    task automatic test_register_extremes();
        int i;
        write_reg(CFG_UNMAPPED, 16'hFFFF);
        write_reg(CFG_LOW_THRESHOLD, 16'h0000);
        write_reg(CFG_RECOVER_THRESHOLD, 16'hF0FF);
        write_reg(CFG_COUNT_LIMIT, 16'd65534);
        for (i = 0; i < 6; i++)
            send_word(pass_word(12'h3C3, 1'b1, 1'b1, 1'b0));
    endtask

    // Out-of-range limit: counter keeps climbing and the alarm never changes
    task automatic test_counter_saturation();
        int i;
        write_reg(CFG_RECOVER_THRESHOLD, 16'h0000);
        write_reg(CFG_LOW_THRESHOLD, 16'hFFFF);
        write_reg(CFG_COUNT_LIMIT, 16'hFFFF);
        pace_free = 1'b1;
        for (i = 0; i < SAT_PASSES; i++)
            send_word(pass_word(12'd100, 1'b1, 1'b1, 1'b0));
        for (i = 0; i < 3; i++)
            send_word(pass_word(12'd100, 1'b0, 1'b1, 1'b0));
        drain_results();
        pace_free = 1'b0;
    endtask

    // Receiver holds off for a long stretch while words keep coming
    task automatic test_backpressure();
        int i;
        pace_free = 1'b1;
        hold_request = 1'b1;
        for (i = 0; i < 40; i++)
            send_word(in_word_t'(15'($urandom)));
        drain_results();
        pace_free = 1'b0;
    endtask

    // Battery level drifts between a low and a healthy zone, with outliers
    task automatic run_passes(int n);
        int i;
        int base;
        int v;
        logic low_zone;
        in_word_t w;
        low_zone = 1'($urandom_range(1));
        base = 0;
        for (i = 0; i < n; i++)
        begin
            if (i % 10 == 0)
            begin
                if ($urandom_range(2) == 0)
                    low_zone = !low_zone;
                if (low_zone)
                    base = (thr_low > 40) ? $urandom_range(thr_low - 40) : 0;
                else
                    base = (thr_recover < 4055) ? $urandom_range(4095, thr_recover + 40)
                                                : 4095;
            end
            if ($urandom_range(9) == 0)
                w = in_word_t'(15'($urandom));
            else
            begin
                v = base + $urandom_range(64) - 32;
                if ($urandom_range(19) == 0)
                    v = $urandom_range(4095);
                if (v < 0)
                    v = 0;
                if (v > 4095)
                    v = 4095;
                w = pass_word(FIELD_BITS'(v), $urandom_range(9) < 7, $urandom_range(9) < 8,
                              $urandom_range(15) == 0);
            end
            send_word(w);
        end
    endtask

    // Several random settings; the last one takes any register value but a zero limit
    task automatic test_random_phases();
        int p;
        int lo;
        for (p = 0; p < 4; p++)
        begin
            if (p == 3)
            begin
                write_reg(CFG_UNMAPPED, 16'($urandom));
                write_reg(CFG_LOW_THRESHOLD, 16'($urandom));
                write_reg(CFG_RECOVER_THRESHOLD, 16'($urandom));
                write_reg(CFG_COUNT_LIMIT, 16'($urandom_range(65535, 1)));
            end
            else
            begin
                lo = $urandom_range(3000, 600);
                write_reg(CFG_LOW_THRESHOLD, 16'(lo));
                write_reg(CFG_RECOVER_THRESHOLD, 16'(lo + $urandom_range(800)));
                write_reg(CFG_COUNT_LIMIT, 16'($urandom_range(p == 0 ? 4 : 40, 1)));
            end
            run_passes(PHASE_PASSES);
        end
    endtask

    // Compare every accepted result word with the oldest prediction
    always @(posedge clk)
    begin
        out_word_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 40)
                    $display("%0t: expected no word, got %p", $time, out_data);
            end
            else
            begin
                want = expected_results.pop_front();
                check_field("average", want.average, out_data.average);
                check_field("average_ready", want.average_ready, out_data.average_ready);
                check_field("low_alarm", want.low_alarm, out_data.low_alarm);
                check_field("blink_request", want.blink_request, out_data.blink_request);
                check_field("alarm_entered", want.alarm_entered, out_data.alarm_entered);
                check_field("alarm_cleared", want.alarm_cleared, out_data.alarm_cleared);
                check_field("hysteresis_count", want.hysteresis_count,
                            out_data.hysteresis_count);
            end
        end
    end

    // Receiver: random stall rates that change over time, plus the long hold-off
    initial
    begin : receiver
        int stall_pct;
        int span;
        stall_pct = 0;
        span = 0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_request = 1'b0;
                out_ready <= 1'b1;
            end
            else if (pace_free)
                out_ready <= 1'b1;
            else
            begin
                if (span == 0)
                begin
                    case ($urandom_range(3))
                        0:       stall_pct = 0;
                        1:       stall_pct = 20;
                        2:       stall_pct = 50;
                        default: stall_pct = 85;
                    endcase
                    span = $urandom_range(80, 10);
                end
                span--;
                out_ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    initial
    begin
        #5_000_000;
        $display("tb: errors");
        $finish;
    end

    initial
    begin
        // reset values of the predicted state and registers
        clear_group();
        level       = '0;
        hyst        = '0;
        alarm_on    = 1'b0;
        blink_on    = 1'b0;
        tick_held   = 1'b0;
        thr_low     = LOW_THRESHOLD_RESET;
        thr_recover = RECOVER_THRESHOLD_RESET;
        hyst_limit  = COUNT_LIMIT_RESET;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_group_extremes();
        test_alarm_cycle();
        test_register_extremes();
        test_counter_saturation();
        test_backpressure();
        test_random_phases();

        drain_results();
        repeat (4) @(posedge clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule

/* battery_level_monitor_core.f */
+incdir+sv
sv/blm_pkg.sv
sv/battery_level_monitor_core.sv
test/tb.sv
